/* rtl/core/rpe_pkg.sv */
`default_nettype none

package rpe_pkg;

	// Element pairs addressable by the pair index port.
	localparam int PAIRS = 64;

	// Rotation steps of the CORDIC array.
	localparam int CORDIC_STEPS = 24;

	// log2(500000) in Q.32 and 1/(2*pi) in Q0.32.
	localparam logic [63:0] LOG2_BASE_Q32     = 64'd81310467867;
	localparam logic [63:0] TURNS_PER_RAD_Q32 = 64'd683565276;

	// Largest integer exponent that still leaves a nonzero increment.
	localparam logic [31:0] MAX_EXP_INT = 32'd38;

	// Start value of the CORDIC x register, Q2.30, prescaled by the inverse gain.
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	// Step angles in Q0.32 turns.
	localparam logic signed [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
		32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
		32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
		32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
		32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
		32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
		32'sd652,       32'sd326,       32'sd163,       32'sd81
	};

	// The two samples of one element pair, carried alongside the angle work.
	typedef struct packed {
		logic signed [15:0] x_first;
		logic signed [15:0] x_second;
	} pair_t;

	// Floor square root, used only while the increment table is elaborated.
	function automatic logic [63:0] isqrt64(input logic [63:0] num);
		logic [63:0] n;
		logic [63:0] res;
		logic [63:0] b;
		n   = num;
		res = '0;
		b   = 64'd1 << 62;
		while (b > n)
			b = b >> 2;
		while (b != 64'd0) begin
			if (n >= res + b) begin
				n   = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// Phase increment in Q0.40 turns per position for a Q.32 exponent e,
	// where the frequency is 2^-e radians per position.
	function automatic logic [39:0] phase_inc(input logic [63:0] e);
		logic [63:0] frac;
		logic [63:0] m;
		logic [63:0] t;
		logic [63:0] r;
		logic [5:0]  ip;
		if (e[63:32] > MAX_EXP_INT)
			return '0;
		ip   = e[37:32];
		frac = {32'd0, e[31:0]};
		m    = 64'h0000_0001_0000_0000;
		t    = isqrt64(64'h8000_0000_0000_0000);
		for (int k = 1; k <= 32; k++) begin
			if (frac[32 - k])
				m = (m * t + 64'h0000_0000_8000_0000) >> 32;
			t = isqrt64(t << 32);
		end
		r = (m * TURNS_PER_RAD_Q32 + (64'd1 << (7'd23 + {1'b0, ip}))) >> (7'd24 + {1'b0, ip});
		return r[39:0];
	endfunction

endpackage

`default_nettype wire

/* rtl/core/rpe_phase.sv */
`default_nettype none

module rpe_phase #(
	parameter int HEAD_LEN = 128
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 in_valid,
	input  wire logic [12:0]          position,
	input  wire logic [5:0]           pair_index,
	input  wire rpe_pkg::pair_t       pair_in,
	output logic                      valid_o,
	output logic [1:0]                quarter_o,
	output logic signed [31:0]        resid_o,
	output rpe_pkg::pair_t            pair_o
);

	// Per-pair phase increments, worked out at elaboration.
	logic [39:0] inc_rom [rpe_pkg::PAIRS];

	for (genvar gj = 0; gj < rpe_pkg::PAIRS; gj++) begin : g_inc
		localparam logic [63:0] EXP =
			(64'(2 * gj) * rpe_pkg::LOG2_BASE_Q32 + 64'(HEAD_LEN / 2)) / 64'(HEAD_LEN);
		localparam logic [39:0] INC = (gj < HEAD_LEN / 2) ? rpe_pkg::phase_inc(EXP) : 40'd0;
		assign inc_rom[gj] = INC;
	end

	logic                 v_s1, v_s2, v_s3;
	logic [39:0]          inc_s1;
	logic [12:0]          pos_s1;
	logic [31:0]          ph_s2;
	logic [1:0]           quarter_s3;
	logic signed [31:0]   resid_s3;
	rpe_pkg::pair_t       pair_s1, pair_s2, pair_s3;

	logic [39:0] ph_full;
	logic [31:0] ph_round;
	logic [1:0]  quarter_d;

	// Only the low 40 bits of the product matter: the phase wraps at one turn.
	assign ph_full   = 40'({27'd0, pos_s1}) * inc_s1;
	// Nearest quarter turn, leaving a residual within one eighth of a turn.
	assign ph_round  = ph_s2 + 32'h2000_0000;
	assign quarter_d = ph_round[31:30];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inc_s1     <= inc_rom[pair_index];
			pos_s1     <= position;
			pair_s1    <= pair_in;
			ph_s2      <= ph_full[39:8];
			pair_s2    <= pair_s1;
			quarter_s3 <= quarter_d;
			resid_s3   <= $signed(ph_s2 - {quarter_d, 30'd0});
			pair_s3    <= pair_s2;
		end
	end

	assign valid_o   = v_s3;
	assign quarter_o = quarter_s3;
	assign resid_o   = resid_s3;
	assign pair_o    = pair_s3;

endmodule

`default_nettype wire

/* rtl/core/rpe_cordic.sv */
`default_nettype none

module rpe_cordic (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 valid_i,
	input  wire logic [1:0]           quarter_i,
	input  wire logic signed [31:0]   resid_i,
	input  wire rpe_pkg::pair_t       pair_i,
	output logic                      valid_o,
	output logic signed [15:0]        cos_o,
	output logic signed [15:0]        sin_o,
	output rpe_pkg::pair_t            pair_o
);

	localparam int N = rpe_pkg::CORDIC_STEPS;

	// Entry 0 is the stage input; entry i+1 is the register after step i.
	logic                 v_s   [N+1];
	logic [1:0]           q_s   [N+1];
	logic signed [33:0]   cx_s  [N+1];
	logic signed [33:0]   cy_s  [N+1];
	logic signed [31:0]   cz_s  [N+1];
	rpe_pkg::pair_t       pr_s  [N+1];

	assign v_s[0]  = valid_i;
	assign q_s[0]  = quarter_i;
	assign cx_s[0] = rpe_pkg::CORDIC_GAIN;
	assign cy_s[0] = '0;
	assign cz_s[0] = resid_i;
	assign pr_s[0] = pair_i;

	for (genvar gi = 0; gi < N; gi++) begin : g_step
		logic signed [33:0] dx, dy;
		logic signed [33:0] nx, ny;
		logic signed [31:0] nz;

		assign dx = cy_s[gi] >>> gi;
		assign dy = cx_s[gi] >>> gi;

		always_comb begin
			if (cz_s[gi] >= 0) begin
				nx = cx_s[gi] - dx;
				ny = cy_s[gi] + dy;
				nz = cz_s[gi] - rpe_pkg::ATAN_TURNS[gi];
			end else begin
				nx = cx_s[gi] + dx;
				ny = cy_s[gi] - dy;
				nz = cz_s[gi] + rpe_pkg::ATAN_TURNS[gi];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[gi+1] <= 1'b0;
			end else if (en) begin
				v_s[gi+1] <= v_s[gi];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[gi+1]  <= q_s[gi];
				cx_s[gi+1] <= nx;
				cy_s[gi+1] <= ny;
				cz_s[gi+1] <= nz;
				pr_s[gi+1] <= pr_s[gi];
			end
		end
	end

	// Round half up from Q2.30 to Q1.15 and clamp to the symmetric range.
	function automatic logic signed [15:0] to_q15(input logic signed [33:0] v);
		logic signed [33:0] r;
		r = (v + 34'sd16384) >>> 15;
		if (r > 34'sd32767)
			return 16'sd32767;
		if (r < -34'sd32767)
			return -16'sd32767;
		return r[15:0];
	endfunction

	logic signed [33:0] c_rot, s_rot;

	// The quarter turn taken out before the rotations is put back exactly.
	always_comb begin
		case (q_s[N])
			2'd1: begin
				c_rot = -cy_s[N];
				s_rot = cx_s[N];
			end
			2'd2: begin
				c_rot = -cx_s[N];
				s_rot = -cy_s[N];
			end
			2'd3: begin
				c_rot = cy_s[N];
				s_rot = -cx_s[N];
			end
			default: begin
				c_rot = cx_s[N];
				s_rot = cy_s[N];
			end
		endcase
	end

	logic                 v_out_q;
	logic signed [15:0]   cos_q, sin_q;
	rpe_pkg::pair_t       pair_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out_q <= 1'b0;
		end else if (en) begin
			v_out_q <= v_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_q  <= to_q15(c_rot);
			sin_q  <= to_q15(s_rot);
			pair_q <= pr_s[N];
		end
	end

	assign valid_o = v_out_q;
	assign cos_o   = cos_q;
	assign sin_o   = sin_q;
	assign pair_o  = pair_q;

endmodule

`default_nettype wire

/* rtl/core/rpe_rotate.sv */
`default_nettype none

module rpe_rotate (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 valid_i,
	input  wire logic signed [15:0]   cos_i,
	input  wire logic signed [15:0]   sin_i,
	input  wire rpe_pkg::pair_t       pair_i,
	output logic                      valid_o,
	output logic signed [15:0]        y_first,
	output logic signed [15:0]        y_second,
	output logic                      clipped
);

	logic                 v_s1, v_s2;
	logic signed [31:0]   fc_s1, ss_s1, sc_s1, fs_s1;
	logic signed [15:0]   yf_s2, ys_s2;
	logic                 clip_s2;

	logic signed [32:0]   acc_f, acc_s;
	logic signed [32:0]   rf, rs;
	logic signed [15:0]   yf_d, ys_d;
	logic                 clip_f, clip_s;

	assign acc_f = 33'(fc_s1) - 33'(ss_s1);
	assign acc_s = 33'(sc_s1) + 33'(fs_s1);
	assign rf    = (acc_f + 33'sd16384) >>> 15;
	assign rs    = (acc_s + 33'sd16384) >>> 15;

	always_comb begin
		clip_f = 1'b1;
		if (rf > 33'sd32767)
			yf_d = 16'sh7fff;
		else if (rf < -33'sd32768)
			yf_d = 16'sh8000;
		else begin
			yf_d   = rf[15:0];
			clip_f = 1'b0;
		end
		clip_s = 1'b1;
		if (rs > 33'sd32767)
			ys_d = 16'sh7fff;
		else if (rs < -33'sd32768)
			ys_d = 16'sh8000;
		else begin
			ys_d   = rs[15:0];
			clip_s = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= valid_i;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fc_s1   <= pair_i.x_first * cos_i;
			ss_s1   <= pair_i.x_second * sin_i;
			sc_s1   <= pair_i.x_second * cos_i;
			fs_s1   <= pair_i.x_first * sin_i;
			yf_s2   <= yf_d;
			ys_s2   <= ys_d;
			clip_s2 <= clip_f | clip_s;
		end
	end

	assign valid_o  = v_s2;
	assign y_first  = yf_s2;
	assign y_second = ys_s2;
	assign clipped  = clip_s2;

endmodule

`default_nettype wire

/* rtl/core/rotary_position_embedding_unit.sv */
`default_nettype none

// Rotary position embedding, half-split form, for one element pair per beat.
// A beat carries element j (x_first) and element j + HEAD_LEN/2 (x_second) of a
// query or key head, the token position and the pair index j. The unit looks up
// the phase increment of pair j (500000^(-2j/HEAD_LEN) radians per position,
// held in turns in a table built at elaboration from HEAD_LEN), multiplies it by
// the position modulo one turn, turns the phase into cos and sin with a
// 24-step CORDIC array, and returns
//   y_first  = x_first * cos - x_second * sin
//   y_second = x_second * cos + x_first * sin
// rounded to nearest and saturated to 16 bits; clipped flags a saturation.
// Pair indexes at or beyond HEAD_LEN/2 use a zero phase and pass unrotated,
// apart from cos being one LSB short of unity. The pipeline takes a new beat
// every cycle unless out_stall holds it: three stages form the
// phase, one per CORDIC step makes 24, one applies the quarter turn and rounds,
// and two form the products and the saturated sums. The whole pipeline holds
// while a result waits on out_stall, so in_stall simply follows
// out_valid and out_stall; no beat is dropped or repeated.

module rotary_position_embedding_unit #(
	parameter int HEAD_LEN = 128
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [12:0]          position,
	input  wire logic [5:0]           pair_index,
	input  wire logic signed [15:0]   x_first,
	input  wire logic signed [15:0]   x_second,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic signed [15:0]        y_first,
	output logic signed [15:0]        y_second,
	output logic                      clipped
);

	// Every stage moves together; it holds only while the output beat is stuck.
	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	rpe_pkg::pair_t pair_in;
	assign pair_in = {x_first, x_second};

	logic                 ph_valid;
	logic [1:0]           ph_quarter;
	logic signed [31:0]   ph_resid;
	rpe_pkg::pair_t       ph_pair;

	rpe_phase #(
		.HEAD_LEN(HEAD_LEN)
	) u_phase (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.position  (position),
		.pair_index(pair_index),
		.pair_in   (pair_in),
		.valid_o   (ph_valid),
		.quarter_o (ph_quarter),
		.resid_o   (ph_resid),
		.pair_o    (ph_pair)
	);

	logic                 cs_valid;
	logic signed [15:0]   cs_cos, cs_sin;
	rpe_pkg::pair_t       cs_pair;

	rpe_cordic u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_i  (ph_valid),
		.quarter_i(ph_quarter),
		.resid_i  (ph_resid),
		.pair_i   (ph_pair),
		.valid_o  (cs_valid),
		.cos_o    (cs_cos),
		.sin_o    (cs_sin),
		.pair_o   (cs_pair)
	);

	rpe_rotate u_rotate (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_i (cs_valid),
		.cos_i   (cs_cos),
		.sin_i   (cs_sin),
		.pair_i  (cs_pair),
		.valid_o (out_valid),
		.y_first (y_first),
		.y_second(y_second),
		.clipped (clipped)
	);

endmodule

`default_nettype wire

/* verif/rotary_position_embedding_unit_tb.sv */
`timescale 1ns / 1ps

// Testbench for the rotary position embedding unit.
//
// Every accepted input beat is run through a bit-exact fixed-point model of the
// rotation that lives in this file: the per-pair phase step table, the phase
// product, the CORDIC array and the rounding and saturation of the outputs.
// The predicted rotation is queued, and each accepted output beat is compared
// field by field against the oldest queued rotation. Both sides of the unit
// idle at random in the first two of three traffic phases, and the sender
// stops after each run of beats until the pipeline has emptied.

module rotary_position_embedding_unit_tb;

	// Build-time shape of the unit under test.
	localparam int HEAD_LEN = 128;
	localparam int PAIRS = 64;
	localparam int ROTATION_STEPS = 24;

	// log2(500000) in Q.32, 1/(2*pi) in Q0.32, and the prescaled CORDIC start.
	localparam longint unsigned LOG2_BASE = 64'd81310467867;
	localparam longint unsigned TURNS_PER_RAD = 64'd683565276;
	localparam longint CORDIC_START = 64'sd652032874;

	// Above this integer exponent the phase step rounds to zero.
	localparam int MAX_EXP_INT = 38;

	// Output samples and cos/sin are 16-bit; cos/sin never reach -1.0.
	localparam longint SAMPLE_MAX = 32767;
	localparam longint SAMPLE_MIN = -32768;
	localparam longint TRIG_LIMIT = 32767;

	// The pipeline is 30 stages deep; the tail wait covers it with margin.
	localparam int TAIL_CYCLES = 40;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic signed [15:0] y_first;
		logic signed [15:0] y_second;
		logic               clipped;
	} rotated_pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [12:0]        position = '0;
	logic [5:0]         pair_index = '0;
	logic signed [15:0] x_first = '0;
	logic signed [15:0] x_second = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [15:0] y_first;
	logic signed [15:0] y_second;
	logic               clipped;

	// Phase step of each pair in Q0.40 turns per position, filled before reset ends.
	longint unsigned phase_step [PAIRS];

	// CORDIC step angles in Q0.32 turns.
	longint arc_turns [ROTATION_STEPS] = '{
		536870912, 316933406, 167458907, 85004756,
		42667331, 21354465, 10679838, 5340245,
		2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861,
		10430, 5215, 2608, 1304,
		652, 326, 163, 81
	};

	// Rotations predicted for accepted beats, oldest first.
	rotated_pair_t rotations_due [$];

	int error_count = 0;
	int unsigned cycle_count = 0;

	// Percent chance per cycle that the sender holds back or the receiver stalls.
	int send_gap_pct = 0;
	int recv_stall_pct = 0;

	rotary_position_embedding_unit #(
		.HEAD_LEN(HEAD_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.position(position),
		.pair_index(pair_index),
		.x_first(x_first),
		.x_second(x_second),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.y_first(y_first),
		.y_second(y_second),
		.clipped(clipped)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Digit-by-digit floor square root of a 64-bit value.
	function automatic longint unsigned floor_sqrt(input longint unsigned v);
		longint unsigned rest;
		longint unsigned root;
		longint unsigned probe;
		rest = v;
		root = 0;
		probe = 64'd1 << 62;
		while (probe > rest)
			probe >>= 2;
		while (probe != 0) begin
			if (rest >= root + probe) begin
				rest -= root + probe;
				root = (root >> 1) + probe;
			end else begin
				root >>= 1;
			end
			probe >>= 2;
		end
		return root;
	endfunction

	// The frequency of pair j is 2^-e radians per position with
	// e = 2j * log2(500000) / HEAD_LEN. The fractional part of e is applied as a
	// product of the factors 2^(-2^-k), each one the square root of the one
	// before, and the integer part as a plain shift.
	function automatic longint unsigned pair_phase_step(input int j);
		longint unsigned expo;
		longint unsigned mant;
		longint unsigned halving;
		int ipart;
		if (j >= HEAD_LEN / 2)
			return 0;
		expo = (2 * 64'(j) * LOG2_BASE + 64'(HEAD_LEN / 2)) / 64'(HEAD_LEN);
		ipart = int'(expo >> 32);
		if (ipart > MAX_EXP_INT)
			return 0;
		mant = 64'd1 << 32;
		halving = floor_sqrt(64'd1 << 63);
		for (int k = 1; k <= 32; k++) begin
			if (expo[32 - k])
				mant = (mant * halving + (64'd1 << 31)) >> 32;
			halving = floor_sqrt(halving << 32);
		end
		return (mant * TURNS_PER_RAD + (64'd1 << (23 + ipart))) >> (24 + ipart);
	endfunction

	// Q2.30 to Q1.15, rounding half up and keeping clear of -1.0.
	function automatic longint trig_to_q15(input longint v);
		longint r;
		r = (v + 16384) >>> 15;
		if (r > TRIG_LIMIT)
			r = TRIG_LIMIT;
		if (r < -TRIG_LIMIT)
			r = -TRIG_LIMIT;
		return r;
	endfunction

	// Q.15 sum to a 16-bit sample, rounding half up; a clamp raises the flag.
	function automatic logic signed [15:0] round_to_sample(input longint acc, inout logic clip);
		longint r;
		r = (acc + 16384) >>> 15;
		if (r > SAMPLE_MAX) begin
			clip = 1'b1;
			r = SAMPLE_MAX;
		end else if (r < SAMPLE_MIN) begin
			clip = 1'b1;
			r = SAMPLE_MIN;
		end
		return r[15:0];
	endfunction

	function automatic rotated_pair_t rotate_pair(input logic [12:0] pos, input logic [5:0] j,
			input logic signed [15:0] xf, input logic signed [15:0] xs);
		longint unsigned phase;
		longint unsigned quarter;
		longint unsigned resid;
		logic signed [31:0] resid_s;
		longint z;
		longint cx;
		longint cy;
		longint dx;
		longint dy;
		longint tmp;
		longint cos_q;
		longint sin_q;
		longint xf_l;
		longint xs_l;
		logic clip;
		rotated_pair_t r;
		// Phase in Q0.32 turns, the product taken modulo one turn in Q0.40.
		phase = ((64'(pos) * phase_step[j]) & 64'hFF_FFFF_FFFF) >> 8;
		// Split off the nearest quarter turn, leaving a residual within 1/8 turn.
		quarter = ((phase + (64'd1 << 29)) >> 30) & 64'd3;
		resid = (phase - (quarter << 30)) & 64'hFFFF_FFFF;
		resid_s = resid[31:0];
		z = resid_s;
		cx = CORDIC_START;
		cy = 0;
		for (int i = 0; i < ROTATION_STEPS; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (z >= 0) begin
				cx -= dx;
				cy += dy;
				z -= arc_turns[i];
			end else begin
				cx += dx;
				cy -= dy;
				z += arc_turns[i];
			end
		end
		// Put the quarter turn back exactly by swapping and negating.
		case (quarter)
			1: begin
				tmp = cx;
				cx = -cy;
				cy = tmp;
			end
			2: begin
				cx = -cx;
				cy = -cy;
			end
			3: begin
				tmp = cx;
				cx = cy;
				cy = -tmp;
			end
			default: ;
		endcase
		cos_q = trig_to_q15(cx);
		sin_q = trig_to_q15(cy);
		xf_l = xf;
		xs_l = xs;
		clip = 1'b0;
		r.y_first = round_to_sample(xf_l * cos_q - xs_l * sin_q, clip);
		r.y_second = round_to_sample(xs_l * cos_q + xf_l * sin_q, clip);
		r.clipped = clip;
		return r;
	endfunction

	// A mismatch is counted and printed with the expected and actual value.
	task automatic check_field(input string field, input logic signed [16:0] want,
			input logic signed [16:0] got);
		if (got !== want) begin
			error_count++;
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
		end
	endtask

	// The receiver stalls at random, one decision per clock.
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	// Both handshakes are sampled at the clock edge, before any driver updates
	// land, so the order of processes in a time step does not matter. An input
	// beat is predicted before an output beat is checked in the same cycle.
	always @(posedge clk) begin
		rotated_pair_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				rotations_due = {rotations_due,
					rotate_pair(position, pair_index, x_first, x_second)};
			if (out_valid && !out_stall) begin
				if (rotations_due.size() == 0) begin
					error_count++;
					$display("%0t ns: output beat with nothing expected, got %0d %0d %0d",
						$time, y_first, y_second, clipped);
				end else begin
					want = rotations_due.pop_front();
					check_field("y_first", want.y_first, y_first);
					check_field("y_second", want.y_second, y_second);
					check_field("clipped", {16'd0, want.clipped}, {16'd0, clipped});
				end
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("rotary_position_embedding_unit_tb: errors");
			$finish;
		end
	end

	// Offers one beat and returns at the edge that accepts it. The valid is only
	// lowered when the sender decides to idle, so back-to-back beats keep it high.
	task automatic send_pair(input logic [12:0] pos, input logic [5:0] j,
			input logic signed [15:0] xf, input logic signed [15:0] xs);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		position <= pos;
		pair_index <= j;
		x_first <= xf;
		x_second <= xs;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Holds the sender off until every predicted rotation has come back. The
	// first edge lets the monitor queue the beat accepted just before.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (rotations_due.size() != 0);
	endtask

	// Mostly full-range samples, with full-scale and small values mixed in.
	function automatic logic signed [15:0] random_sample();
		case ($urandom_range(5))
			0: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
			1: return 16'($urandom_range(511)) - 16'sd256;
			default: return 16'($urandom);
		endcase
	endfunction

	// A zero phase leaves the pair unrotated, with cos one LSB short of unity.
	task automatic test_zero_phase();
		send_pair(13'd0, 6'd0, 16'sh7FFF, 16'sh8000);
		send_pair(13'd0, 6'd63, 16'sh8000, 16'sh7FFF);
		send_pair(13'd0, 6'd17, 16'sd12345, -16'sd4321);
		send_pair(13'd0, 6'd40, -16'sd1, 16'sd0);
		send_pair(13'd0, 6'd32, 16'sh8000, 16'sh8000);
	endtask

	// Corners of the position and pair fields, including positions past the
	// nominal sequence length, which use the same phase formula.
	task automatic test_field_extremes();
		send_pair(13'h1FFF, 6'd0, 16'sh7FFF, 16'sh7FFF);
		send_pair(13'h1FFF, 6'd63, 16'sh8000, 16'sh8000);
		send_pair(13'd1, 6'd0, 16'sh8000, 16'sh7FFF);
		send_pair(13'd1, 6'd63, 16'sh7FFF, 16'sh8000);
		send_pair(13'd4096, 6'd31, 16'sd0, 16'sd0);
		send_pair(13'h1FFF, 6'd32, -16'sd1, -16'sd1);
		send_pair(13'd5461, 6'd1, 16'sd1, -16'sd1);
		send_pair(13'h0AAA, 6'h2A, 16'sh5555, 16'shAAAA);
		send_pair(13'h1555, 6'h15, 16'shAAAA, 16'sh5555);
	endtask

	// Pair 0 turns by one radian per position, so full-scale samples of opposite or
	// equal sign rotated by a few radians overflow and must clamp with the flag set.
	task automatic test_saturation();
		send_pair(13'd1, 6'd0, 16'sh7FFF, 16'sh8000);
		send_pair(13'd1, 6'd0, 16'sh8000, 16'sh7FFF);
		send_pair(13'd2, 6'd0, 16'sh7FFF, 16'sh7FFF);
		send_pair(13'd3, 6'd0, 16'sh8000, 16'sh8000);
		send_pair(13'd5, 6'd0, 16'sh7FFF, 16'sh8000);
		send_pair(13'd6, 6'd0, 16'sh8000, 16'sh7FFF);
	endtask

	// Random beats with the occasional corner position.
	task automatic test_mixed_traffic(input int count);
		logic [12:0] pos;
		logic signed [15:0] xf;
		logic signed [15:0] xs;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(7) == 0)
				pos = $urandom_range(1) ? 13'd0 : 13'h1FFF;
			else
				pos = 13'($urandom);
			xf = random_sample();
			xs = random_sample();
			send_pair(pos, 6'($urandom_range(PAIRS - 1)), xf, xs);
		end
	endtask

	initial begin
		foreach (phase_step[j])
			phase_step[j] = pair_phase_step(j);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed beats and then random traffic, with light sender gaps against
		// a mostly stalled receiver and a full stop after the directed beats and after
		// each random run so the pipeline runs dry and restarts.
		send_gap_pct = 21;
		recv_stall_pct = 68;
		test_zero_phase();
		test_field_extremes();
		test_saturation();
		wait_for_results();
		test_mixed_traffic(320);
		wait_for_results();
		test_mixed_traffic(330);
		wait_for_results();

		// Sparse input into a mostly ready receiver.
		send_gap_pct = 68;
		recv_stall_pct = 21;
		test_mixed_traffic(650);
		wait_for_results();

		// Full rate on both sides.
		send_gap_pct = 0;
		recv_stall_pct = 0;
		test_mixed_traffic(650);
		wait_for_results();

		// Any stray beat after the last expected one is caught by the monitor.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("rotary_position_embedding_unit_tb: clean");
		else
			$display("rotary_position_embedding_unit_tb: errors");
		$finish;
	end

endmodule
